>>> hw/rtl/iqors_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iqors_pkg
// Shared types and codes for the oldest-ready-select issue queue.
// ----------------------------------------------------------------------------
package iqors_pkg;

	localparam int CLS_W = 4;
	localparam int REG_W = 6;
	localparam int PAY_W = 32;

	// operation codes
	localparam logic [2:0] OP_DISPATCH = 3'd0;
	localparam logic [2:0] OP_SET      = 3'd1;
	localparam logic [2:0] OP_CLEAR    = 3'd2;
	localparam logic [2:0] OP_INT      = 3'd3;
	localparam logic [2:0] OP_MUL      = 3'd4;

	// class codes
	localparam logic [3:0] CLS_ALU_RR = 4'd0;
	localparam logic [3:0] CLS_LOAD   = 4'd1;
	localparam logic [3:0] CLS_STORE  = 4'd2;
	localparam logic [3:0] CLS_MOVC   = 4'd3;
	localparam logic [3:0] CLS_ADDL   = 4'd4;
	localparam logic [3:0] CLS_BZ     = 4'd5;
	localparam logic [3:0] CLS_BNZ    = 4'd6;
	localparam logic [3:0] CLS_JUMP   = 4'd7;
	localparam logic [3:0] CLS_MULT   = 4'd8;

	typedef struct packed {
		logic [2:0]       operation;
		logic [CLS_W-1:0] op_class;
		logic [REG_W-1:0] src1_reg;
		logic [REG_W-1:0] src2_reg;
		logic [REG_W-1:0] dest_reg;
		logic [PAY_W-1:0] payload;
		logic [REG_W-1:0] reg_index;
		logic             mul_stalled;
	} in_item_t;

	typedef struct packed {
		logic             issued;
		logic [CLS_W-1:0] issued_class;
		logic [REG_W-1:0] issued_src1;
		logic [REG_W-1:0] issued_src2;
		logic [REG_W-1:0] issued_dest;
		logic [PAY_W-1:0] issued_payload;
		logic             dispatch_dropped;
		logic             queue_full;
		logic             queue_empty;
	} out_item_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_HOLD
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;  // execute accepted item, capture result
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic busy;
	} stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/iqors_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iqors_ctrl
// Handshake controller: accepts one item, holds its result until taken.
// ----------------------------------------------------------------------------
module iqors_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire                  out_stall,
	output iqors_pkg::cmd_t      cmd,
	input  iqors_pkg::stat_t     stat
);

	iqors_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iqors_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state; result register frees when taken, so a new item may enter
	always_comb begin
		logic freed;
		freed    = (state_q == iqors_pkg::ST_IDLE) || !out_stall;
		in_stall = !freed || stat.busy;
		cmd.load = in_valid && !in_stall;
		out_valid = (state_q == iqors_pkg::ST_HOLD);
		unique case (state_q)
			iqors_pkg::ST_IDLE: state_d = cmd.load ? iqors_pkg::ST_HOLD : iqors_pkg::ST_IDLE;
			iqors_pkg::ST_HOLD: state_d = (cmd.load || out_stall) ?
				iqors_pkg::ST_HOLD : iqors_pkg::ST_IDLE;
			default: state_d = iqors_pkg::ST_IDLE;
		endcase
	end

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
	ap_load_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("accepted item gave no result");
	ap_no_load_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !cmd.load)
		else $error("item accepted over a held result");

endmodule
`default_nettype wire

>>> hw/rtl/iqors_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iqors_dpath
// Queue slots, scoreboard, priority select, collapse and result register.
// ----------------------------------------------------------------------------
module iqors_dpath #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PHYS_REGS    = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  iqors_pkg::cmd_t       cmd,
	output iqors_pkg::stat_t      stat,
	input  iqors_pkg::in_item_t   item,
	output iqors_pkg::out_item_t  result
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PW    = (PAYLOAD_BITS < iqors_pkg::PAY_W) ? PAYLOAD_BITS : iqors_pkg::PAY_W;

	typedef struct packed {
		logic [iqors_pkg::CLS_W-1:0] cls;
		logic [iqors_pkg::REG_W-1:0] s1;
		logic [iqors_pkg::REG_W-1:0] s2;
		logic [iqors_pkg::REG_W-1:0] rd;
		logic [PAYLOAD_BITS-1:0]     pay;
	} entry_t;

	entry_t                 slot_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]       occ_q;
	logic [PHYS_REGS-1:0]   rvalid_q;
	iqors_pkg::out_item_t   res_q;

	assign stat.busy = 1'b0;
	assign result    = res_q;

	// scoreboard lookup; registers beyond the file count as valid
	function automatic logic reg_ok(input logic [PHYS_REGS-1:0] v,
		input logic [iqors_pkg::REG_W-1:0] r);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < PHYS_REGS; k++) begin
			if (int'(r) == k) ok = v[k];
		end
		return ok;
	endfunction

	// per-slot readiness, all in parallel
	logic [QUEUE_DEPTH-1:0] rdy;
	always_comb begin
		logic a, b;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			a = reg_ok(rvalid_q, slot_q[i].s1);
			b = reg_ok(rvalid_q, slot_q[i].s2);
			rdy[i] = 1'b0;
			if (CNT_W'(i) < occ_q) begin
				if (item.operation == iqors_pkg::OP_MUL) begin
					rdy[i] = !item.mul_stalled && slot_q[i].cls == iqors_pkg::CLS_MULT && a && b;
				end else if (item.operation == iqors_pkg::OP_INT) begin
					case (slot_q[i].cls)
						iqors_pkg::CLS_ALU_RR: rdy[i] = a && b;
						iqors_pkg::CLS_LOAD, iqors_pkg::CLS_ADDL: rdy[i] = a;
						iqors_pkg::CLS_STORE: rdy[i] = b;
						iqors_pkg::CLS_MOVC, iqors_pkg::CLS_BZ, iqors_pkg::CLS_BNZ,
						iqors_pkg::CLS_JUMP: rdy[i] = 1'b1;
						default: rdy[i] = 1'b0;
					endcase
				end
			end
		end
	end

	// oldest-first pick: one-hot of lowest ready slot, plus the collapse mask
	// (the picked slot and every slot above it take their upper neighbor)
	logic [QUEUE_DEPTH-1:0] pick, behind;
	logic                   hit;
	entry_t                 sel;
	assign pick   = rdy & (~rdy + QUEUE_DEPTH'(1));
	assign behind = ~(pick - QUEUE_DEPTH'(1)) & {QUEUE_DEPTH{hit}};
	assign hit    = |rdy;
	always_comb begin
		sel = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (pick[i]) sel = slot_q[i];
		end
	end

	logic is_disp, full, drop;
	logic [CNT_W-1:0] occ_d;
	assign is_disp = item.operation == iqors_pkg::OP_DISPATCH;
	assign full    = occ_q == CNT_W'(QUEUE_DEPTH);
	assign drop    = is_disp && full;
	assign occ_d   = (is_disp && !full) ? occ_q + CNT_W'(1) : (hit ? occ_q - CNT_W'(1) : occ_q);

	// queue slots: write at tail or shift forward past the issued one
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (is_disp && !full && CNT_W'(i) == occ_q) begin
					slot_q[i].cls <= item.op_class;
					slot_q[i].s1  <= item.src1_reg;
					slot_q[i].s2  <= item.src2_reg;
					slot_q[i].rd  <= item.dest_reg;
					slot_q[i].pay <= PAYLOAD_BITS'(item.payload);
				end else if (behind[i] && i + 1 < QUEUE_DEPTH) begin
					slot_q[i] <= slot_q[(i + 1) % QUEUE_DEPTH];
				end
			end
		end
	end

	// occupancy and scoreboard
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			rvalid_q <= '1;
		end else if (cmd.load) begin
			occ_q <= occ_d;
			for (int k = 0; k < PHYS_REGS; k++) begin
				if (int'(item.reg_index) == k) begin
					if (item.operation == iqors_pkg::OP_SET) rvalid_q[k] <= 1'b1;
					else if (item.operation == iqors_pkg::OP_CLEAR) rvalid_q[k] <= 1'b0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q.issued           <= hit;
			res_q.issued_class     <= hit ? sel.cls : '0;
			res_q.issued_src1      <= hit ? sel.s1 : '0;
			res_q.issued_src2      <= hit ? sel.s2 : '0;
			res_q.issued_dest      <= hit ? sel.rd : '0;
			res_q.issued_payload   <= hit ? iqors_pkg::PAY_W'(sel.pay[PW-1:0]) : '0;
			res_q.dispatch_dropped <= drop;
			res_q.queue_full       <= occ_d == CNT_W'(QUEUE_DEPTH);
			res_q.queue_empty      <= occ_d == '0;
		end
	end

	ap_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pick))
		else $error("more than one slot picked");
	ap_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy out of range");
	ap_issue_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && hit |=> occ_q == $past(occ_q) - CNT_W'(1))
		else $error("issue did not shrink queue");

endmodule
`default_nettype wire

>>> hw/rtl/issue_queue_oldest_ready_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// issue_queue_oldest_ready_select
// Collapsing issue queue with register scoreboard and oldest-ready select.
// ----------------------------------------------------------------------------
// One item per cycle while out_stall is low: each dispatch, scoreboard
// update or issue is done in the cycle it is accepted, a parallel priority
// pick over all slots and a one-step collapse. The result sits in an output
// register; a new item is taken in the cycle the held result is taken, so
// unstalled throughput is one item per clock. No clearing pass follows reset.
module issue_queue_oldest_ready_select #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PHYS_REGS    = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  iqors_pkg::in_item_t   in_data,
	output logic                  out_valid,
	input  wire                   out_stall,
	output iqors_pkg::out_item_t  out_data
);

	iqors_pkg::cmd_t  cmd;
	iqors_pkg::stat_t stat;

	iqors_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .stat(stat)
	);

	iqors_dpath #(
		.QUEUE_DEPTH(QUEUE_DEPTH), .PHYS_REGS(PHYS_REGS), .PAYLOAD_BITS(PAYLOAD_BITS)
	) u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.item(in_data), .result(out_data)
	);

endmodule
`default_nettype wire
